FILE: rtl/shrot_pkg.sv
`default_nettype none

package shrot_pkg;

    // Fixed formats
    localparam int COEF_W        = 32;
    localparam int ROT_W         = 16;
    localparam int REG_W         = 3 * ROT_W;
    localparam int ROT_FRAC_BITS = 14;
    localparam int KF            = 24;   // fraction bits of every constant
    localparam int MID_FRAC      = 20;   // fraction bits of the band-2 matrix
    localparam int N_IN          = 9;
    localparam int N_OUT         = 10;
    localparam int NB            = 5;    // band-2 size
    localparam int N_ROWS        = 3;

    // Band-2 matrix build widths
    localparam int G_FRAC  = 2 * ROT_FRAC_BITS + 1;
    localparam int T_SHIFT = G_FRAC + KF - MID_FRAC;
    localparam int D_W     = ROT_W + 2;
    localparam int GP_W    = 2 * D_W;
    localparam int G_W     = GP_W + 3;
    localparam int LO_W    = 18;
    localparam int HI_W    = G_W - LO_W;
    localparam int K_W     = 26;
    localparam int PL_W    = LO_W + 1 + K_W;
    localparam int PH_W    = HI_W + K_W;
    localparam int ACC_W   = 64;
    localparam int T_W     = 31;
    localparam int BP_W    = K_W + T_W;
    localparam int BM_W    = 32;

    // Item pipeline widths
    localparam int P1_W = ROT_W + COEF_W;
    localparam int S1_W = P1_W + 2;
    localparam int P2_W = BM_W + COEF_W;
    localparam int F_W  = 25;
    localparam int Q_W  = F_W + COEF_W;

    localparam logic [2:0] CNT_LAST = 3'(NB - 1);

    // Band-2 monomial columns
    localparam logic [2:0] M_XY   = 3'd0;
    localparam logic [2:0] M_YZ   = 3'd1;
    localparam logic [2:0] M_ZZ   = 3'd2;
    localparam logic [2:0] M_ZX   = 3'd3;
    localparam logic [2:0] M_XXYY = 3'd4;

    // Directions below this index are single axes (doubled scale)
    localparam logic [2:0] DIR_PAIR_FIRST = 3'd2;

    // Register indexes
    localparam logic [1:0] CFG_ROT_ROW0 = 2'd0;
    localparam logic [1:0] CFG_ROT_ROW1 = 2'd1;
    localparam logic [1:0] CFG_ROT_ROW2 = 2'd2;

    typedef logic signed [K_W-1:0] t_kconst;
    typedef logic signed [F_W-1:0] t_fconst;

    localparam longint SCALE = 64'sd1 <<< KF;

    localparam t_fconst QF_C1 = F_W'((64'sd429043 * SCALE + 64'sd500000) / 64'sd1000000);
    localparam t_fconst QF_C2 = F_W'((64'sd511664 * SCALE + 64'sd500000) / 64'sd1000000);
    localparam t_fconst QF_C3 = F_W'((64'sd743125 * SCALE + 64'sd500000) / 64'sd1000000);
    localparam t_fconst QF_C4 = F_W'((64'sd886227 * SCALE + 64'sd500000) / 64'sd1000000);
    localparam t_fconst QF_C5 = F_W'((64'sd247708 * SCALE + 64'sd500000) / 64'sd1000000);

    localparam t_kconst SH_XY   = K_W'((64'sd1092548 * SCALE + 64'sd500000) / 64'sd1000000);
    localparam t_kconst SH_ZZ   = K_W'((64'sd315392 * SCALE + 64'sd500000) / 64'sd1000000);
    localparam t_kconst SH_XXYY = K_W'((64'sd546274 * SCALE + 64'sd500000) / 64'sd1000000);

    localparam t_kconst IB_A = K_W'((SCALE * 64'sd1000000 + 64'sd546274) / 64'sd1092548);
    localparam t_kconst IB_B = K_W'((SCALE * 64'sd1000000 + 64'sd273137) / 64'sd546274);
    localparam t_kconst IB_Z = K_W'((SCALE * 64'sd1000000 + 64'sd315392) / 64'sd630784);

    localparam t_kconst INV_BASIS [NB][NB] = '{
        '{t_kconst'(0), IB_A, t_kconst'(0), -IB_A, IB_B},
        '{IB_A, t_kconst'(0), IB_Z, -IB_A, IB_A},
        '{IB_B, t_kconst'(0), t_kconst'(0), t_kconst'(0), t_kconst'(0)},
        '{t_kconst'(0), t_kconst'(0), t_kconst'(0), IB_B, t_kconst'(0)},
        '{t_kconst'(0), IB_B, t_kconst'(0), t_kconst'(0), t_kconst'(0)}
    };

    localparam t_kconst ROW_GAIN [NB] = '{SH_XY, SH_XY, SH_ZZ, SH_XY, SH_XXYY};

    // Band-1 output k uses rotation row B1_ROW[k]
    localparam int B1_ROW [N_ROWS] = '{1, 2, 0};

    localparam logic [REG_W-1:0] ROT_ONE = REG_W'(64'sd1 <<< ROT_FRAC_BITS);

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_GMUL,
        SQ_GWR,
        SQ_TMUL,
        SQ_TACC,
        SQ_TRND,
        SQ_BMUL,
        SQ_BWR
    } t_seq_state;

    typedef struct packed {
        logic busy;
        logic g_mul;
        logic g_wr;
        logic t_mul;
        logic t_acc;
        logic t_rnd;
        logic b_mul;
        logic b_wr;
    } t_seq_ctl;

    localparam longint SAT_MAX = (64'sd1 <<< (COEF_W - 1)) - 64'sd1;
    localparam longint SAT_MIN = -(64'sd1 <<< (COEF_W - 1));

    function automatic logic signed [COEF_W-1:0] f_sat32(input logic signed [63:0] v);
        logic signed [COEF_W-1:0] res;
        if (v > SAT_MAX)
            res = COEF_W'(SAT_MAX);
        else if (v < SAT_MIN)
            res = COEF_W'(SAT_MIN);
        else
            res = COEF_W'(v);
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sh_rotate_irradiance_form.sv
`default_nettype none

// SH order-2 rotation and irradiance quadratic form.
// s_axis carries one word per color channel: nine Q15.16 SH coefficients.
// m_axis returns the ten distinct entries of the symmetric 4x4 irradiance
// form for that word, Q15.16, saturated.
// The cfg port writes the three rotation rows (three Q1.14 entries each).
// Throughput: one word per cycle while the sequencer is idle and m_axis is
// not stalled, through a six-stage pipeline (input reg, products, sums,
// round/saturate, form products, output reg).
// The band-2 rotation matrix depends only on the rotation, so a sequencer
// with time-shared multipliers rebuilds it after reset and after every
// rotation write; while it runs, s_axis_tready is low.
// Reset loads the identity rotation and clears the pipeline valid flags.
// When m_axis_tready is low the output register holds; upstream stages keep
// filling bubbles, and back-pressure drops s_axis_tready only once every stage is full.
module sh_rotate_irradiance_form (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // coef_dc, coef_l1_y, coef_l1_z, coef_l1_x, coef_l2_xy, coef_l2_yz,
    // coef_l2_zz, coef_l2_zx, coef_l2_xxyy (32 bits each, lowest first)
    input  wire [shrot_pkg::N_IN*shrot_pkg::COEF_W-1:0]  s_axis_tdata,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    // form_xx, form_xy, form_xz, form_xw, form_yy, form_yz, form_yw,
    // form_zz, form_zw, form_ww (32 bits each, lowest first)
    output logic [shrot_pkg::N_OUT*shrot_pkg::COEF_W-1:0] m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    input  wire                            i_cfg_we,
    input  wire [1:0]                      i_cfg_idx,
    input  wire [shrot_pkg::REG_W-1:0]     i_cfg_data
);
    import shrot_pkg::*;

    // ---------------- rotation registers and sequencer ----------------
    logic [REG_W-1:0]         r_rot_row [N_ROWS];
    logic signed [ROT_W-1:0]  w_r [N_ROWS][N_ROWS];
    t_seq_state               r_state, n_state;
    t_seq_ctl                 w_ctl;
    logic [2:0]               r_ci, r_cm, r_cn;
    logic                     w_cfg_hit;

    logic [1:0]               w_dp, w_dq;
    logic                     w_dpair;
    logic signed [D_W-1:0]    w_d [N_ROWS];
    logic signed [D_W-1:0]    w_ga, w_gb;
    logic signed [GP_W-1:0]   r_gprod;
    logic signed [G_W-1:0]    w_gs, w_gval;
    logic signed [G_W-1:0]    r_g [NB][NB];
    logic signed [G_W-1:0]    w_gsel;
    logic signed [HI_W-1:0]   w_ghi;
    logic signed [PL_W-1:0]   r_pl;
    logic signed [PH_W-1:0]   r_ph;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [T_W-1:0]    r_t;
    logic signed [BP_W-1:0]   r_bprod;
    logic signed [BM_W-1:0]   r_bm [NB][NB];

    localparam logic signed [G_W-1:0] G_ONE  = G_W'(64'sd1 <<< G_FRAC);
    localparam longint                T_HALF = 64'sd1 <<< (T_SHIFT - 1);
    localparam longint                F_HALF = 64'sd1 <<< (KF - 1);
    localparam longint                B1_HALF = 64'sd1 <<< (ROT_FRAC_BITS - 1);
    localparam longint                B2_HALF = 64'sd1 <<< (MID_FRAC - 1);

    assign w_cfg_hit = i_cfg_we && (i_cfg_idx == CFG_ROT_ROW0 ||
                                    i_cfg_idx == CFG_ROT_ROW1 ||
                                    i_cfg_idx == CFG_ROT_ROW2);

    always_comb begin
        for (int j = 0; j < N_ROWS; j++)
            for (int k = 0; k < N_ROWS; k++)
                w_r[j][k] = r_rot_row[j][ROT_W*k +: ROT_W];
    end

    // next state
    always_comb begin
        case (r_state)
            SQ_IDLE: n_state = SQ_IDLE;
            SQ_GMUL: n_state = SQ_GWR;
            SQ_GWR:  n_state = (r_ci == CNT_LAST && r_cm == CNT_LAST) ? SQ_TMUL : SQ_GMUL;
            SQ_TMUL: n_state = SQ_TACC;
            SQ_TACC: n_state = (r_ci == CNT_LAST) ? SQ_TRND : SQ_TMUL;
            SQ_TRND: n_state = SQ_BMUL;
            SQ_BMUL: n_state = SQ_BWR;
            SQ_BWR:  n_state = (r_cm == CNT_LAST && r_cn == CNT_LAST) ? SQ_IDLE : SQ_TMUL;
            default: n_state = SQ_IDLE;
        endcase
        if (w_cfg_hit)
            n_state = SQ_GMUL;
    end

    // state decode
    always_comb begin
        w_ctl = '0;
        case (r_state)
            SQ_IDLE: w_ctl = '0;
            SQ_GMUL: begin w_ctl.busy = 1'b1; w_ctl.g_mul = 1'b1; end
            SQ_GWR:  begin w_ctl.busy = 1'b1; w_ctl.g_wr  = 1'b1; end
            SQ_TMUL: begin w_ctl.busy = 1'b1; w_ctl.t_mul = 1'b1; end
            SQ_TACC: begin w_ctl.busy = 1'b1; w_ctl.t_acc = 1'b1; end
            SQ_TRND: begin w_ctl.busy = 1'b1; w_ctl.t_rnd = 1'b1; end
            SQ_BMUL: begin w_ctl.busy = 1'b1; w_ctl.b_mul = 1'b1; end
            SQ_BWR:  begin w_ctl.busy = 1'b1; w_ctl.b_wr  = 1'b1; end
            default: w_ctl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_GMUL;
            r_ci    <= '0;
            r_cm    <= '0;
            r_cn    <= '0;
            for (int j = 0; j < N_ROWS; j++)
                r_rot_row[j] <= ROT_ONE << (ROT_W * j);
        end else begin
            r_state <= n_state;
            if (w_cfg_hit) begin
                r_rot_row[i_cfg_idx] <= i_cfg_data;
                r_ci <= '0;
                r_cm <= '0;
                r_cn <= '0;
            end else begin
                case (r_state)
                    SQ_GWR: begin
                        if (r_cm == CNT_LAST) begin
                            r_cm <= '0;
                            r_ci <= (r_ci == CNT_LAST) ? 3'd0 : r_ci + 3'd1;
                        end else begin
                            r_cm <= r_cm + 3'd1;
                        end
                    end
                    SQ_TACC: r_ci <= (r_ci == CNT_LAST) ? 3'd0 : r_ci + 3'd1;
                    SQ_BWR: begin
                        if (r_cn == CNT_LAST) begin
                            r_cn <= '0;
                            r_cm <= (r_cm == CNT_LAST) ? 3'd0 : r_cm + 3'd1;
                        end else begin
                            r_cn <= r_cn + 3'd1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // base direction i: column p, plus column q for the diagonal ones
    always_comb begin
        case (r_ci)
            3'd0:    begin w_dp = 2'd0; w_dq = 2'd0; w_dpair = 1'b0; end
            3'd1:    begin w_dp = 2'd2; w_dq = 2'd0; w_dpair = 1'b0; end
            3'd2:    begin w_dp = 2'd0; w_dq = 2'd1; w_dpair = 1'b1; end
            3'd3:    begin w_dp = 2'd0; w_dq = 2'd2; w_dpair = 1'b1; end
            3'd4:    begin w_dp = 2'd1; w_dq = 2'd2; w_dpair = 1'b1; end
            default: begin w_dp = 2'd0; w_dq = 2'd0; w_dpair = 1'b0; end
        endcase
        for (int j = 0; j < N_ROWS; j++)
            w_d[j] = D_W'(w_r[j][w_dp]) + (w_dpair ? D_W'(w_r[j][w_dq]) : D_W'(0));
    end

    // monomial operands; x^2-y^2 taken as (x+y)(x-y)
    always_comb begin
        case (r_cm)
            M_XY:    begin w_ga = w_d[0];          w_gb = w_d[1];          end
            M_YZ:    begin w_ga = w_d[1];          w_gb = w_d[2];          end
            M_ZZ:    begin w_ga = w_d[2];          w_gb = w_d[2];          end
            M_ZX:    begin w_ga = w_d[2];          w_gb = w_d[0];          end
            M_XXYY:  begin w_ga = w_d[0] + w_d[1]; w_gb = w_d[0] - w_d[1]; end
            default: begin w_ga = '0;              w_gb = '0;              end
        endcase
    end

    always_comb begin
        w_gs   = (r_ci < DIR_PAIR_FIRST) ? (G_W'(r_gprod) <<< 1) : G_W'(r_gprod);
        w_gval = (r_cm == M_ZZ) ? (w_gs + (w_gs <<< 1) - G_ONE) : w_gs;
        w_gsel = r_g[r_ci][r_cm];
        w_ghi  = $signed(w_gsel[G_W-1:LO_W]);
        n_acc  = ((r_ci == 3'd0) ? ACC_W'(0) : r_acc)
               + (ACC_W'(r_ph) <<< LO_W) + ACC_W'(r_pl);
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.g_mul)
            r_gprod <= w_ga * w_gb;
        if (w_ctl.g_wr)
            r_g[r_ci][r_cm] <= w_gval;
        if (w_ctl.t_mul) begin
            r_pl <= $signed({1'b0, w_gsel[LO_W-1:0]}) * INV_BASIS[r_ci][r_cn];
            r_ph <= w_ghi * INV_BASIS[r_ci][r_cn];
        end
        if (w_ctl.t_acc)
            r_acc <= n_acc;
        if (w_ctl.t_rnd)
            r_t <= T_W'((r_acc + T_HALF) >>> T_SHIFT);
        if (w_ctl.b_mul)
            r_bprod <= ROW_GAIN[r_cm] * r_t;
        if (w_ctl.b_wr)
            r_bm[r_cm][r_cn] <= BM_W'((ACC_W'(r_bprod) + F_HALF) >>> KF);
    end

    // ---------------- item pipeline ----------------
    logic [6:1]               r_vld;
    logic [6:1]               w_en;
    logic                     w_acc_in;

    logic signed [COEF_W-1:0] r_c [N_IN];
    logic signed [P1_W-1:0]   r_p1 [N_ROWS][N_ROWS];
    logic signed [P2_W-1:0]   r_p2 [NB][NB];
    logic signed [COEF_W-1:0] r_c0_2, r_c0_3;
    logic signed [S1_W-1:0]   r_s1 [N_ROWS];
    logic signed [ACC_W-1:0]  r_s2 [NB];
    logic signed [COEF_W-1:0] r_lr [N_IN];
    logic signed [Q_W-1:0]    r_q [N_OUT+1];
    logic signed [COEF_W-1:0] r_o [N_OUT];

    always_comb begin
        w_en[6] = !r_vld[6] || m_axis_tready;
        for (int k = 5; k >= 1; k--)
            w_en[k] = !r_vld[k] || w_en[k+1];
    end

    assign s_axis_tready = w_en[1] && !w_ctl.busy && !w_cfg_hit;
    assign w_acc_in      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_vld[6];

    always_comb begin
        for (int k = 0; k < N_OUT; k++)
            m_axis_tdata[COEF_W*k +: COEF_W] = r_o[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1])
                r_vld[1] <= w_acc_in;
            for (int k = 2; k <= 6; k++)
                if (w_en[k])
                    r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: input word
        if (w_acc_in)
            for (int k = 0; k < N_IN; k++)
                r_c[k] <= s_axis_tdata[COEF_W*k +: COEF_W];

        // stage 2: products
        if (w_en[2]) begin
            r_c0_2 <= r_c[0];
            for (int k = 0; k < N_ROWS; k++) begin
                r_p1[k][0] <= w_r[B1_ROW[k]][1] * r_c[1];
                r_p1[k][1] <= w_r[B1_ROW[k]][2] * r_c[2];
                r_p1[k][2] <= w_r[B1_ROW[k]][0] * r_c[3];
            end
            for (int m = 0; m < NB; m++)
                for (int n = 0; n < NB; n++)
                    r_p2[m][n] <= r_bm[m][n] * r_c[4+n];
        end

        // stage 3: sums
        if (w_en[3]) begin
            r_c0_3 <= r_c0_2;
            for (int k = 0; k < N_ROWS; k++)
                r_s1[k] <= S1_W'(r_p1[k][0]) + S1_W'(r_p1[k][1]) + S1_W'(r_p1[k][2]);
            for (int m = 0; m < NB; m++)
                r_s2[m] <= ACC_W'(r_p2[m][0]) + ACC_W'(r_p2[m][1]) + ACC_W'(r_p2[m][2])
                         + ACC_W'(r_p2[m][3]) + ACC_W'(r_p2[m][4]);
        end

        // stage 4: rotated coefficients; bands 1 and 2 rounded and saturated
        if (w_en[4]) begin
            r_lr[0] <= r_c0_3;
            for (int k = 0; k < N_ROWS; k++)
                r_lr[1+k] <= f_sat32((ACC_W'(r_s1[k]) + B1_HALF) >>> ROT_FRAC_BITS);
            for (int m = 0; m < NB; m++)
                r_lr[4+m] <= f_sat32((r_s2[m] + B2_HALF) >>> MID_FRAC);
        end

        // stage 5: form products
        if (w_en[5]) begin
            r_q[0]  <= QF_C1 * r_lr[8];
            r_q[1]  <= QF_C1 * r_lr[4];
            r_q[2]  <= QF_C1 * r_lr[7];
            r_q[3]  <= QF_C2 * r_lr[3];
            r_q[4]  <= QF_C4 * r_lr[0];
            r_q[5]  <= QF_C1 * r_lr[5];
            r_q[6]  <= QF_C2 * r_lr[1];
            r_q[7]  <= QF_C3 * r_lr[6];
            r_q[8]  <= QF_C2 * r_lr[2];
            r_q[9]  <= QF_C5 * r_lr[6];
            r_q[10] <= '0;
        end

        // stage 6: output register; form_yy rounds the negated product
        if (w_en[6]) begin
            r_o[0] <= f_sat32((ACC_W'(r_q[0]) + F_HALF) >>> KF);
            r_o[1] <= f_sat32((ACC_W'(r_q[1]) + F_HALF) >>> KF);
            r_o[2] <= f_sat32((ACC_W'(r_q[2]) + F_HALF) >>> KF);
            r_o[3] <= f_sat32((ACC_W'(r_q[3]) + F_HALF) >>> KF);
            r_o[4] <= f_sat32((F_HALF - ACC_W'(r_q[0])) >>> KF);
            r_o[5] <= f_sat32((ACC_W'(r_q[5]) + F_HALF) >>> KF);
            r_o[6] <= f_sat32((ACC_W'(r_q[6]) + F_HALF) >>> KF);
            r_o[7] <= f_sat32((ACC_W'(r_q[7]) + F_HALF) >>> KF);
            r_o[8] <= f_sat32((ACC_W'(r_q[8]) + F_HALF) >>> KF);
            r_o[9] <= f_sat32((ACC_W'(r_q[4]) - ACC_W'(r_q[9]) + ACC_W'(r_q[10])
                               + F_HALF) >>> KF);
        end
    end

endmodule

`default_nettype wire

FILE: verif/sh_rotate_irradiance_form_test.sv
`default_nettype none

module sh_rotate_irradiance_form_test;
    import shrot_pkg::*;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [N_OUT*COEF_W-1:0] t_form_word;

    // constants, 24 fraction bits, rounded from their decimal values
    localparam longint ONE_K   = 64'sd1 <<< 24;
    localparam longint K_C1    = (64'sd429043 * ONE_K + 64'sd500000) / 64'sd1000000;
    localparam longint K_C2    = (64'sd511664 * ONE_K + 64'sd500000) / 64'sd1000000;
    localparam longint K_C3    = (64'sd743125 * ONE_K + 64'sd500000) / 64'sd1000000;
    localparam longint K_C4    = (64'sd886227 * ONE_K + 64'sd500000) / 64'sd1000000;
    localparam longint K_C5    = (64'sd247708 * ONE_K + 64'sd500000) / 64'sd1000000;
    localparam longint K_XY    = (64'sd1092548 * ONE_K + 64'sd500000) / 64'sd1000000;
    localparam longint K_ZZ    = (64'sd315392 * ONE_K + 64'sd500000) / 64'sd1000000;
    localparam longint K_XXYY  = (64'sd546274 * ONE_K + 64'sd500000) / 64'sd1000000;
    localparam longint K_IA    = (ONE_K * 64'sd1000000 + 64'sd546274) / 64'sd1092548;
    localparam longint K_IB    = (ONE_K * 64'sd1000000 + 64'sd273137) / 64'sd546274;
    localparam longint K_IZ    = (ONE_K * 64'sd1000000 + 64'sd315392) / 64'sd630784;
    localparam int     WDOG_LIMIT = 5000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam logic [ROT_W-1:0] Q_ONE  = 16'h4000;
    localparam logic [ROT_W-1:0] Q_MONE = 16'hC000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic [N_IN*COEF_W-1:0] s_axis_tdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    t_form_word m_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [REG_W-1:0] i_cfg_data = '0;

    sh_rotate_irradiance_form dut (
        .i_clk, .i_rst_n,
        .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
        .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state: shadow copy of the rotation rows
    logic [REG_W-1:0] rot_shadow [N_ROWS];
    t_form_word form_pending [$];
    int  n_errors = 0;
    int  n_words_in = 0;
    int  n_words_out = 0;
    int  n_cfg_writes = 0;
    bit  idle_on = 1'b1;      // random gaps on both sides
    int  hold_req = 0;        // long receiver hold-off, in cycles

    string field_name [N_OUT] = '{"form_xx", "form_xy", "form_xz", "form_xw", "form_yy",
                                  "form_yz", "form_yw", "form_zz", "form_zw", "form_ww"};

    // band-2 inverse basis; rows are directions, columns band-2 coefficients
    longint inv_basis [NB][NB] = '{
        '{0, K_IA, 0, -K_IA, K_IB},
        '{K_IA, 0, K_IZ, -K_IA, K_IA},
        '{K_IB, 0, 0, 0, 0},
        '{0, 0, 0, K_IB, 0},
        '{0, K_IB, 0, 0, 0}
    };
    longint band2_gain [NB] = '{K_XY, K_XY, K_ZZ, K_XY, K_XXYY};
    // base direction = column p (+ column q); q < 0 means single axis
    int dir_p [NB] = '{0, 2, 0, 0, 1};
    int dir_q [NB] = '{-1, -1, 1, 2, 2};

    // round half up, done in offset-binary so the shift is logical
    function automatic longint round_shift(longint v, int s);
        longint unsigned u;
        u = longint'(v) + 64'h8000_0000_0000_0000 + (64'd1 << (s - 1));
        u = u >> s;
        return longint'(u) - longint'(64'h8000_0000_0000_0000 >> s);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_form_word irradiance_form(t_coef coef [N_IN]);
        longint c [N_IN];
        longint r [N_ROWS][N_ROWS];
        longint lr [N_IN];
        longint g [NB][NB];
        longint bm [NB][NB];
        longint d [N_ROWS];
        longint f, t, acc;
        longint fo [N_OUT];
        t_form_word w;
        for (int i = 0; i < N_IN; i++)
            c[i] = longint'(coef[i]);
        for (int i = 0; i < N_ROWS; i++)
            for (int j = 0; j < N_ROWS; j++)
                r[i][j] = longint'($signed(rot_shadow[i][16*j +: 16]));
        // band 0 passes, band 1 uses permuted rows
        lr[0] = c[0];
        lr[1] = clamp32(round_shift(r[1][1]*c[1] + r[1][2]*c[2] + r[1][0]*c[3], 14));
        lr[2] = clamp32(round_shift(r[2][1]*c[1] + r[2][2]*c[2] + r[2][0]*c[3], 14));
        lr[3] = clamp32(round_shift(r[0][1]*c[1] + r[0][2]*c[2] + r[0][0]*c[3], 14));
        // monomials of the rotated base directions, 29 fraction bits
        for (int i = 0; i < NB; i++) begin
            f = (dir_q[i] < 0) ? 2 : 1;
            for (int j = 0; j < N_ROWS; j++)
                d[j] = r[j][dir_p[i]] + ((dir_q[i] < 0) ? 0 : r[j][dir_q[i]]);
            g[i][0] = f * d[0] * d[1];
            g[i][1] = f * d[1] * d[2];
            g[i][2] = 3 * f * d[2] * d[2] - (64'sd1 <<< 29);
            g[i][3] = f * d[2] * d[0];
            g[i][4] = f * (d[0] * d[0] - d[1] * d[1]);
        end
        for (int m = 0; m < NB; m++)
            for (int n = 0; n < NB; n++) begin
                t = 0;
                for (int i = 0; i < NB; i++)
                    t += g[i][m] * inv_basis[i][n];
                t = round_shift(t, 33);
                bm[m][n] = round_shift(band2_gain[m] * t, 24);
            end
        for (int m = 0; m < NB; m++) begin
            acc = 0;
            for (int n = 0; n < NB; n++)
                acc += bm[m][n] * c[4 + n];
            lr[4 + m] = clamp32(round_shift(acc, 20));
        end
        fo[0] = round_shift(K_C1 * lr[8], 24);
        fo[1] = round_shift(K_C1 * lr[4], 24);
        fo[2] = round_shift(K_C1 * lr[7], 24);
        fo[3] = round_shift(K_C2 * lr[3], 24);
        fo[4] = round_shift(-(K_C1 * lr[8]), 24);   // negated before rounding
        fo[5] = round_shift(K_C1 * lr[5], 24);
        fo[6] = round_shift(K_C2 * lr[1], 24);
        fo[7] = round_shift(K_C3 * lr[6], 24);
        fo[8] = round_shift(K_C2 * lr[2], 24);
        fo[9] = round_shift(K_C4 * lr[0] - K_C5 * lr[6], 24);
        for (int k = 0; k < N_OUT; k++)
            w[k*COEF_W +: COEF_W] = COEF_W'(clamp32(fo[k]));
        return w;
    endfunction

    // ---- sender: one coefficient word per call ----
    task automatic send_coefs(t_coef coef [N_IN]);
        int gap;
        gap = idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        for (int i = 0; i < N_IN; i++)
            s_axis_tdata[i*COEF_W +: COEF_W] <= coef[i];
        s_axis_tvalid <= 1'b1;
        // config is static while words are in flight
        form_pending.insert(form_pending.size(), irradiance_form(coef));
        do @(posedge i_clk); while (!s_axis_tready);
        n_words_in++;
    endtask

    // drop valid, let every result come home, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (form_pending.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_rot(logic [1:0] idx, logic [REG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= CFG_ROT_ROW2)
            rot_shadow[idx] = val;
        n_cfg_writes++;
    endtask

    task automatic load_rotation(logic [REG_W-1:0] r0, logic [REG_W-1:0] r1,
                                 logic [REG_W-1:0] r2);
        write_rot(CFG_ROT_ROW0, r0);
        write_rot(CFG_ROT_ROW1, r1);
        write_rot(CFG_ROT_ROW2, r2);
    endtask

    function automatic t_coef rand_coef();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12)
            return t_coef'($urandom);
        if (sel < 17)
            return t_coef'($signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000);
        case ($urandom_range(0, 4))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return 32'shFFFF_FFFF;
            default: return 32'sh0001_0000;
        endcase
    endfunction

    task automatic send_random(int count);
        t_coef coef [N_IN];
        for (int k = 0; k < count; k++) begin
            for (int i = 0; i < N_IN; i++)
                coef[i] = rand_coef();
            send_coefs(coef);
        end
    endtask

    // signed permutation matrix, unit entries
    function automatic logic [3*REG_W-1:0] rand_perm_rotation();
        int perm [3] = '{0, 1, 2};
        int a, b, tmp;
        logic [3*REG_W-1:0] rows = '0;
        a = $urandom_range(0, 2);
        b = $urandom_range(0, 2);
        tmp = perm[a]; perm[a] = perm[b]; perm[b] = tmp;
        for (int i = 0; i < 3; i++)
            rows[i*REG_W + perm[i]*ROT_W +: ROT_W] = $urandom_range(0, 1) ? Q_ONE : Q_MONE;
        return rows;
    endfunction

    // ---- receiver ----
    initial begin
        int stall;
        @(posedge i_rst_n);
        m_axis_tready <= 1'b1;
        forever begin
            do @(posedge i_clk); while (!m_axis_tvalid && hold_req == 0);
            if (hold_req > 0) begin
                stall = hold_req;
                hold_req = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 17) : 0;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ---- result checker ----
    always @(posedge i_clk) begin
        t_form_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_words_out++;
            if (form_pending.size() == 0) begin
                $error("unexpected form word %h", m_axis_tdata);
                n_errors++;
            end else begin
                want = form_pending.pop_front();
                for (int k = 0; k < N_OUT; k++)
                    if (m_axis_tdata[k*COEF_W +: COEF_W] !== want[k*COEF_W +: COEF_W]) begin
                        $error("%s expected %h actual %h", field_name[k],
                               want[k*COEF_W +: COEF_W], m_axis_tdata[k*COEF_W +: COEF_W]);
                        n_errors++;
                    end
            end
        end
    end

    // ---- watchdog: cycles with no word moving on either side ----
    always @(posedge i_clk) begin
        int quiet;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", quiet);
            $display("sh_rotate_irradiance_form regression: fail");
            $finish;
        end
    end

    // ---- tests ----

    // reset rotation is the identity; field extremes one at a time
    task automatic test_field_extremes();
        t_coef coef [N_IN];
        t_coef xv [4] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF, 32'sh0000_0001};
        for (int i = 0; i < N_IN; i++) coef[i] = 0;
        send_coefs(coef);
        for (int i = 0; i < N_IN; i++) coef[i] = 32'sh7FFF_FFFF;
        send_coefs(coef);
        for (int i = 0; i < N_IN; i++) coef[i] = 32'sh8000_0000;
        send_coefs(coef);
        // single-field impulses at both ends
        for (int f = 0; f < N_IN; f++) begin
            for (int i = 0; i < N_IN; i++) coef[i] = 0;
            coef[f] = xv[f % 4];
            send_coefs(coef);
        end
        // ties in the negated entry: small L22 values of both signs
        for (int k = 1; k < 4; k++) begin
            for (int i = 0; i < N_IN; i++) coef[i] = 0;
            coef[8] = t_coef'(k);
            send_coefs(coef);
            coef[8] = -t_coef'(k);
            send_coefs(coef);
        end
        drain();
    endtask

    // extreme and non-orthonormal rows; rotated values saturate
    task automatic test_rotation_extremes();
        load_rotation({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        send_random(20);
        drain();
        load_rotation({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        send_random(20);
        drain();
        load_rotation('0, '0, '0);
        send_random(10);
        drain();
        load_rotation({16'h7FFF, 16'h8000, 16'h0000}, {16'hFFFF, 16'h0001, 16'h8000},
                      {16'h0000, 16'h7FFF, 16'hFFFF});
        send_random(20);
        drain();
    endtask

    // a write to the unused index leaves the rotation alone
    task automatic test_unused_index();
        load_rotation({16'h0000, 16'h0000, Q_ONE}, {16'h0000, Q_ONE, 16'h0000},
                      {Q_ONE, 16'h0000, 16'h0000});
        write_rot(CFG_UNUSED, {3{16'h5A5A}});
        send_random(20);
        drain();
    endtask

    // signed permutations and fully random rows, idle on and off
    task automatic test_random_rotations();
        logic [3*REG_W-1:0] rows;
        for (int ph = 0; ph < 10; ph++) begin
            if (ph % 3 == 2)
                rows = (3*REG_W)'({$urandom, $urandom, $urandom, $urandom, $urandom});
            else
                rows = rand_perm_rotation();
            load_rotation(rows[0 +: REG_W], rows[REG_W +: REG_W], rows[2*REG_W +: REG_W]);
            idle_on = (ph % 4 != 3);
            send_random(70);
            drain();
        end
        idle_on = 1'b1;
    endtask

    // receiver holds off long while the sender streams back to back
    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_req = 300;
        send_random(60);
        drain();
        idle_on = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < N_ROWS; i++)
            rot_shadow[i] = ROT_ONE << (ROT_W * i);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_unused_index();
        test_rotation_extremes();
        test_backpressure();
        test_random_rotations();
        // back to identity at the end
        load_rotation(ROT_ONE, ROT_ONE << ROT_W, ROT_ONE << (2 * ROT_W));
        send_random(80);
        drain();
        if (form_pending.size() != 0) begin
            $error("%0d form words never arrived", form_pending.size());
            n_errors++;
        end
        $display("covered %0d coefficient words, %0d form words, %0d register writes",
                 n_words_in, n_words_out, n_cfg_writes);
        $display("rotations: identity, permutations, extremes, random rows; long stall");
        if (n_errors == 0) begin
            $display("sh_rotate_irradiance_form regression: pass");
        end else begin
            $display("sh_rotate_irradiance_form regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
